### hw/rtl/spsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsc_pkg
// Types and constants shared by the scan point smoothness classifier.
// ----------------------------------------------------------------------------
package spsc_pkg;

  localparam int SMOOTH_W = 24;   // Q8.16 smoothness
  localparam int VEC_W    = 41;   // signed difference sum, |S| < 2^40
  localparam int MAG_W    = 40;
  localparam int HALF_W   = 20;   // squaring split into two 40x20 products
  localparam int PROD_W   = 80;
  localparam int ACC_A_W  = 82;   // sum of three |S|^2
  localparam int ACC_B_W  = 64;   // sum of three |c|^2
  localparam int RW       = 114;  // 2^32 * ACC_A
  localparam int DW       = 80;   // ACC_B * (2*window_half)^2
  localparam int TW       = 130;  // root trial sums
  localparam int SQ_STEPS = 12;   // six squares, two products each

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam logic [2:0] REG_CLOUD_SIZE    = 3'd0;
  localparam logic [2:0] REG_WINDOW_HALF   = 3'd1;
  localparam logic [2:0] REG_EDGE_LOW      = 3'd2;
  localparam logic [2:0] REG_EDGE_HIGH     = 3'd3;
  localparam logic [2:0] REG_PLANAR_HIGH   = 3'd4;
  localparam logic [2:0] REG_OUTLIER_LEVEL = 3'd5;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_ORIGIN,
    STAT_WINDOW,
    STAT_BAD_INDEX
  } spsc_status_t;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_EDGE,
    CLS_PLANAR,
    CLS_OUTLIER
  } spsc_class_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CENTER,
    ST_GATHER,
    ST_DIFF,
    ST_SQ,
    ST_SCALE,
    ST_KICK,
    ST_ROOT,
    ST_DONE
  } spsc_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } spsc_root_stat_t;

endpackage

### hw/rtl/scan_point_smoothness_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_point_smoothness_classifier_unit
// Point memory for one circular scan line with a curvature-style smoothness
// measure and feature classing per evaluated point.
// ----------------------------------------------------------------------------
// Input transfers carry a store (tuser 0: point written at point_index) or an
// evaluate (tuser 1: point_index taken as centre). A store gives no result.
// An evaluate gives exactly one result transfer.
// Evaluate steps: centre read, then one neighbour read per cycle from the
// single point memory port (2*window_half reads), six squares as twelve
// products of a 40x20 multiplier, a scale step and a bit-serial root.
// An index or window error goes straight to the result; a centre at the
// origin ends the evaluate after the centre read.
// One item is worked at a time; the next is taken once the current result
// sits in the output register, so a stalled receiver holds at most one
// finished result and blocks the following evaluate only at its end.
// Reset clears control and restores register defaults; the point memory is
// not cleared and must be written before it is evaluated. The user writes
// configuration through cfg_we/cfg_addr/cfg_wdata while idle; not enforced here.
// ----------------------------------------------------------------------------
module scan_point_smoothness_classifier_unit
  import spsc_pkg::*;
#(
  parameter int MAX_POINTS = 4096,
  parameter int MAX_HALF   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // point_index, coord_x, coord_y, coord_z, zero pad
  input  logic         in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // result_index, smoothness, feature_class, status
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [23:0]  cfg_wdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int XW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam logic [XW-1:0] NMax    = XW'(MAX_POINTS);
  localparam logic [10:0]   HalfMax = 11'(MAX_HALF);

  // configuration
  logic [12:0]         cloud_size_r;
  logic [6:0]          window_r;
  logic [SMOOTH_W-1:0] edge_low_r, edge_high_r, planar_high_r, outlier_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cloud_size_r  <= 13'd4096;
      window_r      <= 7'd8;
      edge_low_r    <= 24'd1966;
      edge_high_r   <= 24'd5243;
      planar_high_r <= 24'd590;
      outlier_r     <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CLOUD_SIZE:    cloud_size_r  <= cfg_wdata[12:0];
        REG_WINDOW_HALF:   window_r      <= cfg_wdata[6:0];
        REG_EDGE_LOW:      edge_low_r    <= cfg_wdata;
        REG_EDGE_HIGH:     edge_high_r   <= cfg_wdata;
        REG_PLANAR_HIGH:   planar_high_r <= cfg_wdata;
        REG_OUTLIER_LEVEL: outlier_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input decode
  logic          func;
  logic [11:0]   in_idx;
  logic [XW-1:0] idx_ext, cs_ext, n_eff;
  logic [7:0]    cnt;
  logic          bad_idx, bad_win, store_ok, accept;

  assign func     = in_tuser;
  assign in_idx   = in_tdata[11:0];
  assign idx_ext  = XW'(in_idx);
  assign cs_ext   = XW'(cloud_size_r);
  assign n_eff    = (cs_ext > NMax) ? NMax : cs_ext;
  assign cnt      = {window_r, 1'b0};
  assign bad_idx  = (idx_ext >= n_eff);
  assign bad_win  = (window_r == 7'd0) || (11'(window_r) > HalfMax) ||
                    (XW'({window_r, 1'b1}) > n_eff);
  assign store_ok = (idx_ext < NMax);
  assign accept   = in_tvalid && in_tready;

  // state
  spsc_state_t         state_r, state_nxt;
  logic [11:0]         idx_r, idx_nxt;
  logic [XW-1:0]       n_r, n_nxt;
  logic [XW-1:0]       prev_r, prev_nxt, next_r, next_nxt;
  logic                side_r, side_nxt;
  logic [7:0]          issue_r, issue_nxt;
  logic signed [VEC_W-1:0] nsum_r [3];
  logic signed [VEC_W-1:0] nsum_nxt [3];
  logic signed [VEC_W-1:0] vec_r [6];   // S x,y,z then centre x,y,z
  logic signed [VEC_W-1:0] vec_nxt [6];
  logic signed [VEC_W-1:0] scaled [3];
  logic [15:0]         cnt2_r, cnt2_nxt;
  logic [3:0]          k_r, k_nxt;
  logic                pv_r, pv_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic                to_a_r, to_a_nxt;
  logic [ACC_A_W-1:0]  acc_a_r, acc_a_nxt;
  logic [ACC_B_W-1:0]  acc_b_r, acc_b_nxt;
  logic [DW-1:0]       d_r, d_nxt;
  logic [SMOOTH_W-1:0] res_smooth_r, res_smooth_nxt;
  spsc_class_t         res_class_r, res_class_nxt;
  spsc_status_t        res_status_r, res_status_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [39:0]         out_tdata_r, out_tdata_nxt;

  // point memory, {z, y, x}
  logic [95:0]   mem [MAX_POINTS];
  logic [95:0]   rdata_r;
  logic          mem_we;
  logic [AW-1:0] rd_addr;
  logic [XW-1:0] rd_addr_x, prev_dec, next_inc;
  logic          center_zero, issue_go;

  assign mem_we = accept && (func == FUNC_STORE) && store_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_ext[AW-1:0]] <= in_tdata[107:12];
    end
    rdata_r <= mem[rd_addr];
  end

  assign prev_dec    = (prev_r == '0) ? n_r - XW'(1) : prev_r - XW'(1);
  assign next_inc    = (next_r + XW'(1) == n_r) ? '0 : next_r + XW'(1);
  assign center_zero = (rdata_r == 96'd0);
  assign issue_go    = ((state_r == ST_CENTER) && !center_zero) ||
                       ((state_r == ST_GATHER) && (issue_r < cnt));
  assign rd_addr_x   = (state_r == ST_IDLE) ? idx_ext : (side_r ? next_inc : prev_dec);
  assign rd_addr     = rd_addr_x[AW-1:0];

  // root unit
  spsc_root_stat_t     root_stat;
  logic [SMOOTH_W-1:0] root_q;

  spsc_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_KICK),
    .rad   ({acc_a_r, 32'd0}),
    .den   (d_r),
    .stat  (root_stat),
    .q     (root_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (func == FUNC_EVAL)) begin
          state_nxt = (bad_idx || bad_win) ? ST_DONE : ST_CENTER;
        end
      end
      ST_CENTER: state_nxt = center_zero ? ST_DONE : ST_GATHER;
      ST_GATHER: begin
        if (issue_r == cnt) state_nxt = ST_DIFF;
      end
      ST_DIFF:   state_nxt = ST_SQ;
      ST_SQ: begin
        if (k_r == 4'(SQ_STEPS)) state_nxt = ST_SCALE;
      end
      ST_SCALE:  state_nxt = ST_KICK;
      ST_KICK:   state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_stat.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scaled[i] = $signed({1'b0, cnt}) * vec_r[3 + i];
    end
  end

  // datapath
  logic [2:0]          el;
  logic signed [VEC_W-1:0] sq_v, sq_abs;
  logic [MAG_W-1:0]    mag;
  logic [HALF_W-1:0]   half;
  logic [59:0]         part;

  assign el     = k_r[3:1];
  assign sq_v   = vec_r[el];
  assign sq_abs = sq_v[VEC_W-1] ? -sq_v : sq_v;
  assign mag    = sq_abs[MAG_W-1:0];
  assign half   = k_r[0] ? mag[MAG_W-1:HALF_W] : mag[HALF_W-1:0];
  assign part   = mag * half;

  always_comb begin
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    side_nxt       = side_r;
    issue_nxt      = issue_r;
    nsum_nxt       = nsum_r;
    vec_nxt        = vec_r;
    cnt2_nxt       = cnt2_r;
    k_nxt          = k_r;
    pv_nxt         = 1'b0;
    prod_nxt       = prod_r;
    to_a_nxt       = to_a_r;
    acc_a_nxt      = acc_a_r;
    acc_b_nxt      = acc_b_r;
    d_nxt          = d_r;
    res_smooth_nxt = res_smooth_r;
    res_class_nxt  = res_class_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    if (issue_go) begin
      side_nxt  = ~side_r;
      issue_nxt = issue_r + 8'd1;
      if (side_r) next_nxt = next_inc;
      else        prev_nxt = prev_dec;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && (func == FUNC_EVAL)) begin
          idx_nxt        = in_idx;
          n_nxt          = n_eff;
          prev_nxt       = idx_ext;
          next_nxt       = idx_ext;
          side_nxt       = 1'b0;
          issue_nxt      = 8'd0;
          res_smooth_nxt = '0;
          res_class_nxt  = CLS_NONE;
          res_status_nxt = bad_idx ? STAT_BAD_INDEX : (bad_win ? STAT_WINDOW : STAT_OK);
        end
      end
      ST_CENTER: begin
        vec_nxt[3] = VEC_W'($signed(rdata_r[31:0]));
        vec_nxt[4] = VEC_W'($signed(rdata_r[63:32]));
        vec_nxt[5] = VEC_W'($signed(rdata_r[95:64]));
        for (int i = 0; i < 3; i++) nsum_nxt[i] = '0;
        if (center_zero) res_status_nxt = STAT_ORIGIN;
      end
      ST_GATHER: begin
        nsum_nxt[0] = nsum_r[0] + VEC_W'($signed(rdata_r[31:0]));
        nsum_nxt[1] = nsum_r[1] + VEC_W'($signed(rdata_r[63:32]));
        nsum_nxt[2] = nsum_r[2] + VEC_W'($signed(rdata_r[95:64]));
      end
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) vec_nxt[i] = scaled[i] - nsum_r[i];
        cnt2_nxt  = 16'(cnt) * 16'(cnt);
        k_nxt     = 4'd0;
        acc_a_nxt = '0;
        acc_b_nxt = '0;
      end
      ST_SQ: begin
        if (k_r != 4'(SQ_STEPS)) begin
          prod_nxt = k_r[0] ? {part, 20'd0} : {20'd0, part};
          to_a_nxt = (el < 3'd3);
          pv_nxt   = 1'b1;
          k_nxt    = k_r + 4'd1;
        end
        if (pv_r) begin
          if (to_a_r) acc_a_nxt = acc_a_r + ACC_A_W'(prod_r);
          else        acc_b_nxt = acc_b_r + prod_r[ACC_B_W-1:0];
        end
      end
      ST_SCALE: d_nxt = DW'(acc_b_r) * DW'(cnt2_r);
      ST_ROOT: begin
        if (root_stat.done) begin
          res_smooth_nxt = root_q;
          if (root_q > outlier_r)
            res_class_nxt = CLS_OUTLIER;
          else if ((root_q > edge_low_r) && (root_q < edge_high_r))
            res_class_nxt = CLS_EDGE;
          else if (root_q < planar_high_r)
            res_class_nxt = CLS_PLANAR;
          else
            res_class_nxt = CLS_NONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {res_status_r, res_class_r, res_smooth_r, idx_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    side_r       <= side_nxt;
    issue_r      <= issue_nxt;
    nsum_r       <= nsum_nxt;
    vec_r        <= vec_nxt;
    cnt2_r       <= cnt2_nxt;
    k_r          <= k_nxt;
    pv_r         <= pv_nxt;
    prod_r       <= prod_nxt;
    to_a_r       <= to_a_nxt;
    acc_a_r      <= acc_a_nxt;
    acc_b_r      <= acc_b_nxt;
    d_r          <= d_nxt;
    res_smooth_r <= res_smooth_nxt;
    res_class_r  <= res_class_nxt;
    res_status_r <= res_status_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  // checks
  a_root_owned: assert property (@(posedge clk) disable iff (!rst_n)
    root_stat.busy |-> (state_r == ST_ROOT))
    else $error("root unit busy outside root state");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_tvalid && !out_tready) |=> (state_r == ST_DONE))
    else $error("finished result left before output register freed");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GATHER) |-> (issue_r <= cnt))
    else $error("neighbour reads beyond window");

  a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && func == FUNC_EVAL && bad_idx) |=>
      (state_r == ST_DONE && res_status_r == STAT_BAD_INDEX))
    else $error("bad index not reported");

endmodule

### hw/rtl/spsc_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsc_root
// Bit-serial search for the largest q with q^2 * den <= rad, most significant
// bit first; each bit forms the trial sum, then compares it and commits.
// ----------------------------------------------------------------------------
module spsc_root
  import spsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [RW-1:0]       rad,
  input  logic [DW-1:0]       den,
  output spsc_root_stat_t     stat,
  output logic [SMOOTH_W-1:0] q
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                phase_r, phase_nxt;
  logic [4:0]          bit_r, bit_nxt;
  logic [SMOOTH_W-1:0] q_r, q_nxt;
  logic [TW-1:0]       q2d_r, q2d_nxt;  // q^2 * den
  logic [TW-1:0]       g_r, g_nxt;      // (q * den) << (bit + 1)
  logic [TW-1:0]       e_r, e_nxt;      // den << (2 * bit)
  logic [TW-1:0]       t1_r, t1_nxt;
  logic [TW-1:0]       cand;
  logic                fits;

  assign cand = t1_r + e_r;
  assign fits = (cand <= TW'(rad));

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    q_nxt     = q_r;
    q2d_nxt   = q2d_r;
    g_nxt     = g_r;
    e_nxt     = e_r;
    t1_nxt    = t1_r;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      bit_nxt   = 5'(SMOOTH_W - 1);
      q_nxt     = '0;
      q2d_nxt   = '0;
      g_nxt     = '0;
      e_nxt     = TW'(den) << (2 * (SMOOTH_W - 1));
    end else if (busy_r) begin
      if (!phase_r) begin
        t1_nxt    = q2d_r + g_r;
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        e_nxt     = e_r >> 2;
        if (fits) begin
          q_nxt[bit_r] = 1'b1;
          q2d_nxt      = cand;
          g_nxt        = (g_r >> 1) + e_r;
        end else begin
          g_nxt = g_r >> 1;
        end
        if (bit_r == 5'd0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
    end
    bit_r <= bit_nxt;
    q_r   <= q_nxt;
    q2d_r <= q2d_nxt;
    g_r   <= g_nxt;
    e_r   <= e_nxt;
    t1_r  <= t1_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign q         = q_r;

endmodule
